// File: hw/rtl/wcbt_pkg.sv
// Shared types and constants of the worker circuit breaker table.
package wcbt_pkg;

    // Operation codes of an input beat
    typedef enum logic [1:0] {
        OP_REPORT  = 2'd0,
        OP_FAILURE = 2'd1,
        OP_RESTORE = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    // Breaker states as stored and reported
    typedef enum logic [1:0] {
        BRK_CLOSED = 2'd0,
        BRK_HALF   = 2'd1,
        BRK_OPEN   = 2'd2
    } t_brk;

    // Query classification codes
    typedef enum logic [2:0] {
        QC_UNKNOWN       = 3'd0,
        QC_CLOSED_OK     = 3'd1,
        QC_CLOSED_BAD    = 3'd2,
        QC_PROBE_CLAIMED = 3'd3,
        QC_PROBED_OTHER  = 3'd4,
        QC_OPEN          = 3'd5
    } t_qclass;

    // Error kind that carries the heavy failure weight
    localparam logic [1:0] EK_HOST_DOWN = 2'd1;

    // Configuration register indexes
    localparam logic [1:0] CFG_FAIL_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_OPEN_WAIT      = 2'd1;
    localparam logic [1:0] CFG_RECHECK_WAIT   = 2'd2;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Input beat
    typedef struct packed {
        logic [1:0]  operation;
        logic [5:0]  worker_index;
        logic        from_worker;
        logic        reports_unhealthy;
        logic [31:0] report_time;
        logic [1:0]  error_kind;
        logic        skip_slow;
        logic [31:0] now_seconds;
    } t_in_item;

    // Result beat
    typedef struct packed {
        logic        known;
        logic [1:0]  breaker_state;
        logic        selected;
        logic [2:0]  query_class;
    } t_out_item;

    // One table entry
    typedef struct packed {
        t_brk        brk;
        logic [15:0] err_count;
        logic        probing;
        logic [31:0] opened_at;
        logic [31:0] last_report_seen;
        logic        unhealthy;
        logic [31:0] report_stamp;
    } t_entry;

endpackage

// File: hw/rtl/wcbt_stream_if.sv
// Valid/ready stream interface carrying one payload per beat.
interface wcbt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hw/rtl/worker_circuit_breaker_table.sv
// Top level of the worker circuit breaker table: entry memory, update logic, result register.
//
//  channel  dir  payload                 handshake
//  i_in     in   wcbt_pkg::t_in_item     valid & ready
//  o_out    out  wcbt_pkg::t_out_item    valid & ready
//  i_cfg_*  in   index + 32-bit data     write enable only
//
// Beats pass stage one, then the result register; one beat enters per cycle unless stalled.
// Stage one reads the entry memory (registered read), stage two updates the entry,
// writes it back and loads the result register. A last-write bypass covers
// back-to-back beats on the same worker.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// A full result register that is not taken stalls both stages and the input.
module worker_circuit_breaker_table #(
    parameter int unsigned WORKERS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    wcbt_stream_if.sink                         i_in,
    wcbt_stream_if.source                       o_out,
    input  logic                                i_cfg_we,
    input  logic [wcbt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [wcbt_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int unsigned AW = (WORKERS > 1) ? $clog2(WORKERS) : 1;

    // Configuration registers
    logic [15:0] r_fail_threshold;
    logic [31:0] r_open_wait;
    logic [31:0] r_recheck_wait;

    // Pipeline registers
    logic                 r_s1_valid;
    wcbt_pkg::t_in_item   r_s1;
    wcbt_pkg::t_entry     r_rd_data;
    logic                 r_out_valid;
    wcbt_pkg::t_out_item  r_out;

    // Entry store, valid bits and last-write bypass
    wcbt_pkg::t_entry     mem [WORKERS];
    logic [WORKERS-1:0]   r_valid;
    logic                 r_wb_valid;
    logic [AW-1:0]        r_wb_addr;
    wcbt_pkg::t_entry     r_wb_data;

    logic                 en;
    logic                 rd_in_table;
    logic [AW-1:0]        rd_addr;
    logic                 s1_in_table;
    logic [AW-1:0]        s1_addr;
    logic                 s1_known;
    wcbt_pkg::t_entry     e;
    wcbt_pkg::t_entry     n_entry;
    logic                 create;
    logic                 wr_en;
    logic                 open_over;
    logic [16:0]          weight;
    logic [16:0]          sum;
    logic [15:0]          sat;
    logic                 sel;
    wcbt_pkg::t_qclass    qc;
    wcbt_pkg::t_out_item  n_out;

    // Advance whenever the result register can take a new beat
    assign en          = !r_out_valid || o_out.ready;
    assign i_in.ready  = en;
    assign o_out.valid = r_out_valid;
    assign o_out.payload = r_out;

    assign rd_in_table = (32'(i_in.payload.worker_index) < WORKERS);
    assign rd_addr     = AW'(i_in.payload.worker_index);
    assign s1_in_table = (32'(r_s1.worker_index) < WORKERS);
    assign s1_addr     = AW'(r_s1.worker_index);
    assign s1_known    = s1_in_table && r_valid[s1_addr];

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_threshold <= 16'd3;
            r_open_wait      <= 32'd60;
            r_recheck_wait   <= 32'd10;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                wcbt_pkg::CFG_FAIL_THRESHOLD: r_fail_threshold <= i_cfg_data[15:0];
                wcbt_pkg::CFG_OPEN_WAIT:      r_open_wait      <= i_cfg_data;
                wcbt_pkg::CFG_RECHECK_WAIT:   r_recheck_wait   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Update one entry for the beat in stage two
    always_comb begin
        e         = (r_wb_valid && r_wb_addr == s1_addr) ? r_wb_data : r_rd_data;
        n_entry   = e;
        create    = 1'b0;
        sel       = 1'b0;
        qc        = wcbt_pkg::QC_UNKNOWN;
        open_over = (r_s1.now_seconds - e.opened_at) > r_open_wait;
        weight    = (r_s1.error_kind == wcbt_pkg::EK_HOST_DOWN)
                    ? ({1'b0, r_fail_threshold} + 17'd1) : 17'd1;
        sum       = {1'b0, e.err_count} + weight;
        sat       = (sum > 17'h0FFFF) ? 16'hFFFF : sum[15:0];
        unique case (wcbt_pkg::t_op'(r_s1.operation))
            wcbt_pkg::OP_REPORT: begin
                if (s1_in_table && !s1_known) begin
                    create                   = 1'b1;
                    n_entry.brk              = wcbt_pkg::BRK_CLOSED;
                    n_entry.err_count        = '0;
                    n_entry.probing          = 1'b0;
                    n_entry.opened_at        = '0;
                    n_entry.last_report_seen = r_s1.now_seconds;
                    n_entry.unhealthy        = r_s1.reports_unhealthy;
                    n_entry.report_stamp     = r_s1.report_time;
                end else if (s1_known) begin
                    n_entry.last_report_seen = r_s1.now_seconds;
                    if (e.report_stamp < r_s1.report_time) begin
                        n_entry.report_stamp = r_s1.report_time;
                        n_entry.unhealthy    = r_s1.reports_unhealthy;
                    end
                    if (e.brk == wcbt_pkg::BRK_OPEN && open_over) begin
                        n_entry.brk       = wcbt_pkg::BRK_HALF;
                        n_entry.err_count = '0;
                    end
                    if (n_entry.brk == wcbt_pkg::BRK_HALF && r_s1.from_worker) begin
                        n_entry.brk       = wcbt_pkg::BRK_CLOSED;
                        n_entry.err_count = '0;
                        n_entry.probing   = 1'b0;
                    end
                end
            end
            wcbt_pkg::OP_FAILURE: begin
                if (s1_known && e.brk != wcbt_pkg::BRK_OPEN) begin
                    n_entry.err_count = sat;
                    if ({1'b0, sat} > {1'b0, r_fail_threshold} ||
                        e.brk == wcbt_pkg::BRK_HALF) begin
                        n_entry.brk       = wcbt_pkg::BRK_OPEN;
                        n_entry.err_count = '0;
                        n_entry.probing   = 1'b0;
                        n_entry.opened_at = r_s1.now_seconds;
                    end
                end
            end
            wcbt_pkg::OP_RESTORE: begin
                if (s1_known && e.brk == wcbt_pkg::BRK_HALF) begin
                    n_entry.probing = 1'b0;
                end
            end
            wcbt_pkg::OP_QUERY: begin
                if (!s1_known) begin
                    qc  = wcbt_pkg::QC_UNKNOWN;
                    sel = 1'b1;
                end else begin
                    unique case (e.brk)
                        wcbt_pkg::BRK_CLOSED: begin
                            qc  = e.unhealthy ? wcbt_pkg::QC_CLOSED_BAD
                                              : wcbt_pkg::QC_CLOSED_OK;
                            sel = !(r_s1.skip_slow && e.unhealthy &&
                                    ((r_s1.now_seconds - e.last_report_seen)
                                     < r_recheck_wait));
                        end
                        wcbt_pkg::BRK_HALF: begin
                            if (e.probing) begin
                                qc = wcbt_pkg::QC_PROBED_OTHER;
                            end else begin
                                n_entry.probing = 1'b1;
                                qc              = wcbt_pkg::QC_PROBE_CLAIMED;
                                sel             = 1'b1;
                            end
                        end
                        default: begin
                            qc = wcbt_pkg::QC_OPEN;
                            if (open_over) begin
                                n_entry.brk       = wcbt_pkg::BRK_HALF;
                                n_entry.err_count = '0;
                            end
                        end
                    endcase
                end
            end
            default: ;
        endcase
        wr_en               = en && r_s1_valid && (s1_known || create);
        n_out.known         = s1_known;
        n_out.breaker_state = s1_known ? 2'(n_entry.brk) : 2'd0;
        n_out.selected      = sel;
        n_out.query_class   = 3'(qc);
    end

    // Read the entry memory and hold it while stalled
    always_ff @(posedge i_clk) begin
        if (en && rd_in_table) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Write back the updated entry
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[s1_addr] <= n_entry;
        end
    end

    // Track valid bits and the last write for the bypass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_wb_valid <= 1'b0;
        end else if (wr_en) begin
            r_valid[s1_addr] <= 1'b1;
            r_wb_valid       <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_wb_addr <= s1_addr;
            r_wb_data <= n_entry;
        end
    end

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid  <= i_in.valid;
            r_out_valid <= r_s1_valid;
        end
    end

    // Load stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1  <= i_in.payload;
            r_out <= n_out;
        end
    end

    // A result beat appears only after a beat sat in stage two
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid))
        else $error("result beat without a beat in stage two");

    // A selected known worker is closed or has just claimed its probe
    a_sel_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.known && r_out.selected) |->
        (r_out.query_class == 3'(wcbt_pkg::QC_CLOSED_OK) ||
         r_out.query_class == 3'(wcbt_pkg::QC_CLOSED_BAD) ||
         r_out.query_class == 3'(wcbt_pkg::QC_PROBE_CLAIMED)))
        else $error("selected worker with a non-selectable class");

    // Entries are never dropped once created
    a_valid_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) >= $past($countones(r_valid)))
        else $error("entry valid bit cleared");

    // A stalled result freezes stage two
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |=> ($stable(r_s1_valid) && !$past(wr_en)))
        else $error("stage two moved during a stall");

endmodule

// File: sim/tb_worker_circuit_breaker_table.sv
// Self-checking testbench for the worker circuit breaker table.
`timescale 1ns / 1ps

module tb_worker_circuit_breaker_table;

    localparam int unsigned WORKERS = 64;
    // Register index past the end of the list; writes to it must be ignored
    localparam logic [wcbt_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam logic [1:0] EK_OTHER   = 2'd0;
    localparam logic [1:0] EK_TIMEOUT = 2'd2;
    localparam logic [1:0] EK_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_CHOKE
    } t_rx_mode;

    logic clk = 1'b0;
    logic rst_n;
    logic                            i_cfg_we;
    logic [wcbt_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [wcbt_pkg::CFG_DATA_W-1:0] i_cfg_data;

    wcbt_stream_if #(.T(wcbt_pkg::t_in_item))  in_if ();
    wcbt_stream_if #(.T(wcbt_pkg::t_out_item)) out_if ();

    worker_circuit_breaker_table #(
        .WORKERS(WORKERS)
    ) u_dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        .i_in(in_if),
        .o_out(out_if),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always #2 clk = ~clk;

    // Mirror of the breaker table and its registers
    logic           wk_valid     [WORKERS];
    wcbt_pkg::t_brk wk_state     [WORKERS];
    logic [15:0]    wk_fails     [WORKERS];
    logic           wk_probing   [WORKERS];
    logic [31:0]    wk_opened_at [WORKERS];
    logic [31:0]    wk_seen_at   [WORKERS];
    logic           wk_unhealthy [WORKERS];
    logic [31:0]    wk_stamp     [WORKERS];
    logic [15:0]    thr_cfg;
    logic [31:0]    open_wait_cfg;
    logic [31:0]    recheck_cfg;

    wcbt_pkg::t_in_item  op_feed_q [$];
    wcbt_pkg::t_out_item breaker_result_q [$];
    int unsigned mismatches = 0;

    // Sender and receiver pacing
    int unsigned burst_left = 4;
    int unsigned gap_left = 0;
    bit          drain_hold = 1'b0;
    bit          drained_once = 1'b0;
    bit          in_taken = 1'b0;
    t_rx_mode    rx_mode = RX_OPEN;
    int unsigned rx_left = 0;
    logic [15:0] rx_pat = '0;

    // Random stream state
    logic [5:0]  hot_workers [8];
    logic [31:0] now_t;
    logic [31:0] stamp_t;

    function automatic logic wait_elapsed(input logic [31:0] now_s, input logic [31:0] since,
                                          input logic [31:0] wait_s);
        logic [31:0] age;
        age = now_s - since;
        return age > wait_s;
    endfunction

    // Apply one beat to the mirror table and return the result it must produce
    function automatic wcbt_pkg::t_out_item predict_breaker(input wcbt_pkg::t_in_item it);
        logic [5:0]          w;
        logic                was_known;
        logic [16:0]         weight;
        logic [16:0]         sum;
        logic [31:0]         seen_age;
        wcbt_pkg::t_out_item res;
        w = it.worker_index;
        was_known = wk_valid[w];
        res = '0;
        case (wcbt_pkg::t_op'(it.operation))
            wcbt_pkg::OP_REPORT: begin
                if (!was_known) begin
                    wk_valid[w] = 1'b1;
                    wk_state[w] = wcbt_pkg::BRK_CLOSED;
                    wk_fails[w] = '0;
                    wk_probing[w] = 1'b0;
                    wk_opened_at[w] = '0;
                    wk_seen_at[w] = it.now_seconds;
                    wk_unhealthy[w] = it.reports_unhealthy;
                    wk_stamp[w] = it.report_time;
                end else begin
                    wk_seen_at[w] = it.now_seconds;
                    // keep only the newer health report
                    if (wk_stamp[w] < it.report_time) begin
                        wk_stamp[w] = it.report_time;
                        wk_unhealthy[w] = it.reports_unhealthy;
                    end
                    if (wk_state[w] == wcbt_pkg::BRK_OPEN &&
                        wait_elapsed(it.now_seconds, wk_opened_at[w], open_wait_cfg)) begin
                        wk_state[w] = wcbt_pkg::BRK_HALF;
                        wk_fails[w] = '0;
                    end
                    if (wk_state[w] == wcbt_pkg::BRK_HALF && it.from_worker) begin
                        wk_state[w] = wcbt_pkg::BRK_CLOSED;
                        wk_fails[w] = '0;
                        wk_probing[w] = 1'b0;
                    end
                end
            end
            wcbt_pkg::OP_FAILURE: begin
                if (was_known && wk_state[w] != wcbt_pkg::BRK_OPEN) begin
                    weight = (it.error_kind == wcbt_pkg::EK_HOST_DOWN)
                             ? {1'b0, thr_cfg} + 17'd1 : 17'd1;
                    sum = {1'b0, wk_fails[w]} + weight;
                    if (sum > 17'h0FFFF) sum = 17'h0FFFF;
                    wk_fails[w] = sum[15:0];
                    if (sum > {1'b0, thr_cfg} || wk_state[w] == wcbt_pkg::BRK_HALF) begin
                        wk_state[w] = wcbt_pkg::BRK_OPEN;
                        wk_fails[w] = '0;
                        wk_probing[w] = 1'b0;
                        wk_opened_at[w] = it.now_seconds;
                    end
                end
            end
            wcbt_pkg::OP_RESTORE: begin
                if (was_known && wk_state[w] == wcbt_pkg::BRK_HALF) wk_probing[w] = 1'b0;
            end
            wcbt_pkg::OP_QUERY: begin
                if (!was_known) begin
                    res.query_class = wcbt_pkg::QC_UNKNOWN;
                    res.selected = 1'b1;
                end else if (wk_state[w] == wcbt_pkg::BRK_CLOSED) begin
                    res.query_class = wk_unhealthy[w] ? wcbt_pkg::QC_CLOSED_BAD
                                                      : wcbt_pkg::QC_CLOSED_OK;
                    res.selected = 1'b1;
                    seen_age = it.now_seconds - wk_seen_at[w];
                    if (it.skip_slow && wk_unhealthy[w] && seen_age < recheck_cfg)
                        res.selected = 1'b0;
                end else if (wk_state[w] == wcbt_pkg::BRK_HALF) begin
                    if (wk_probing[w]) begin
                        res.query_class = wcbt_pkg::QC_PROBED_OTHER;
                    end else begin
                        wk_probing[w] = 1'b1;
                        res.query_class = wcbt_pkg::QC_PROBE_CLAIMED;
                        res.selected = 1'b1;
                    end
                end else begin
                    res.query_class = wcbt_pkg::QC_OPEN;
                    if (wait_elapsed(it.now_seconds, wk_opened_at[w], open_wait_cfg)) begin
                        wk_state[w] = wcbt_pkg::BRK_HALF;
                        wk_fails[w] = '0;
                    end
                end
            end
        endcase
        res.known = was_known;
        res.breaker_state = wk_valid[w] ? wk_state[w] : wcbt_pkg::BRK_CLOSED;
        return res;
    endfunction

    function automatic void check_field(input string fname, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    function automatic wcbt_pkg::t_in_item make_beat(input wcbt_pkg::t_op op,
                                                     input logic [5:0] w,
                                                     input logic fw, input logic unh,
                                                     input logic [31:0] rtime,
                                                     input logic [1:0] ek,
                                                     input logic skip,
                                                     input logic [31:0] now_s);
        wcbt_pkg::t_in_item it;
        it.operation = op;
        it.worker_index = w;
        it.from_worker = fw;
        it.reports_unhealthy = unh;
        it.report_time = rtime;
        it.error_kind = ek;
        it.skip_slow = skip;
        it.now_seconds = now_s;
        return it;
    endfunction

    // Queue one directed beat
    function automatic void queue_beat(input wcbt_pkg::t_op op, input logic [5:0] w,
                                       input logic fw, input logic unh,
                                       input logic [31:0] rtime, input logic [1:0] ek,
                                       input logic skip, input logic [31:0] now_s);
        op_feed_q.push_back(make_beat(op, w, fw, unh, rtime, ek, skip, now_s));
    endfunction

    // Monitor: predict on every input beat, check every result beat
    always @(posedge clk) begin
        wcbt_pkg::t_out_item want;
        if (rst_n) begin
            if (in_if.valid && in_if.ready) begin
                breaker_result_q.push_back(predict_breaker(in_if.payload));
                in_taken = 1'b1;
            end
            if (out_if.valid && out_if.ready) begin
                if (breaker_result_q.size() == 0) begin
                    $display("%0t ns: result beat with none expected, actual %h",
                             $time, out_if.payload);
                    mismatches++;
                end else begin
                    want = breaker_result_q.pop_front();
                    check_field("known", 32'(want.known), 32'(out_if.payload.known));
                    check_field("breaker_state", 32'(want.breaker_state),
                                32'(out_if.payload.breaker_state));
                    check_field("selected", 32'(want.selected), 32'(out_if.payload.selected));
                    check_field("query_class", 32'(want.query_class),
                                32'(out_if.payload.query_class));
                end
            end
        end
    end

    // Driver: hold a beat until taken, send in bursts, sometimes drain the block first
    always @(negedge clk) begin
        if (!(in_if.valid && !in_taken)) begin
            in_taken = 1'b0;
            if (gap_left != 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (drain_hold) begin
                in_if.valid <= 1'b0;
                if (breaker_result_q.size() == 0) begin
                    drain_hold = 1'b0;
                    drained_once = 1'b1;
                end
            end else if (op_feed_q.size() != 0) begin
                in_if.payload <= op_feed_q.pop_front();
                in_if.valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    if (!drained_once || $urandom_range(0, 15) == 0) drain_hold = 1'b1;
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall in modes of random length
    always @(negedge clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 80);
            rx_pat = 16'($urandom);
        end
        rx_left--;
        rx_pat = {rx_pat[14:0], rx_pat[15]};
        case (rx_mode)
            RX_OPEN:    out_if.ready <= 1'b1;
            RX_COIN:    out_if.ready <= 1'($urandom_range(0, 1));
            RX_PATTERN: out_if.ready <= rx_pat[0];
            RX_CHOKE:   out_if.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic write_reg(input logic [wcbt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(negedge clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            wcbt_pkg::CFG_FAIL_THRESHOLD: thr_cfg = val[15:0];
            wcbt_pkg::CFG_OPEN_WAIT:      open_wait_cfg = val;
            wcbt_pkg::CFG_RECHECK_WAIT:   recheck_cfg = val;
            default: ;
        endcase
        @(negedge clk);
        i_cfg_we <= 1'b0;
    endtask

    // Wait until every beat is sent and every result has come back
    task automatic wait_idle();
        do @(posedge clk); while (op_feed_q.size() != 0 || in_if.valid);
        while (breaker_result_q.size() != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic start_phase(input logic [15:0] thr, input logic [31:0] ow,
                               input logic [31:0] rw);
        write_reg(wcbt_pkg::CFG_FAIL_THRESHOLD, {16'h0, thr});
        write_reg(wcbt_pkg::CFG_OPEN_WAIT, ow);
        write_reg(wcbt_pkg::CFG_RECHECK_WAIT, rw);
        for (int i = 0; i < 8; i++) hot_workers[3'(i)] = 6'($urandom_range(0, WORKERS - 1));
        now_t = $urandom;
        stamp_t = $urandom;
        @(posedge clk);
    endtask

    // Random beats, mostly on a few hot workers with a slowly advancing clock
    task automatic queue_random_beats(input int unsigned count);
        wcbt_pkg::t_in_item it;
        int unsigned        pick;
        for (int unsigned k = 0; k < count; k++) begin
            it = make_beat(wcbt_pkg::OP_REPORT, '0, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), '0, EK_OTHER,
                           1'($urandom_range(0, 1)), '0);
            pick = $urandom_range(0, 99);
            if (pick < 30) it.operation = wcbt_pkg::OP_REPORT;
            else if (pick < 60) it.operation = wcbt_pkg::OP_FAILURE;
            else if (pick < 70) it.operation = wcbt_pkg::OP_RESTORE;
            else it.operation = wcbt_pkg::OP_QUERY;
            it.worker_index = ($urandom_range(0, 9) < 8)
                              ? hot_workers[3'($urandom_range(0, 7))]
                              : 6'($urandom_range(0, WORKERS - 1));
            pick = $urandom_range(0, 99);
            if (pick < 80) now_t = now_t + $urandom_range(0, 4);
            else if (pick < 95) now_t = now_t + $urandom_range(0, 40);
            else now_t = $urandom;
            it.now_seconds = now_t;
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                stamp_t = stamp_t + $urandom_range(0, 3);
                it.report_time = stamp_t;
            end else if (pick < 90) begin
                it.report_time = stamp_t - $urandom_range(1, 50);
            end else begin
                it.report_time = $urandom;
            end
            pick = $urandom_range(0, 99);
            if (pick < 20) it.error_kind = wcbt_pkg::EK_HOST_DOWN;
            else if (pick < 25) it.error_kind = EK_UNUSED;
            else if (pick < 60) it.error_kind = EK_TIMEOUT;
            else it.error_kind = EK_OTHER;
            op_feed_q.push_back(it);
        end
    endtask

    initial begin
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        rst_n = 1'b0;
        thr_cfg = 16'd3;
        open_wait_cfg = 32'd60;
        recheck_cfg = 32'd10;
        wk_valid = '{default: 1'b0};
        wk_state = '{default: wcbt_pkg::BRK_CLOSED};
        wk_fails = '{default: 16'd0};
        wk_probing = '{default: 1'b0};
        wk_opened_at = '{default: 32'd0};
        wk_seen_at = '{default: 32'd0};
        wk_unhealthy = '{default: 1'b0};
        wk_stamp = '{default: 32'd0};
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        @(posedge clk);

        // Directed walk through the breaker life cycle at reset settings
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd1000);
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, wcbt_pkg::EK_HOST_DOWN,
                   1'b0, 32'd1000);
        queue_beat(wcbt_pkg::OP_RESTORE, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd1000);
        queue_beat(wcbt_pkg::OP_REPORT, 6'd0, 1'b0, 1'b1, 32'd100, EK_OTHER, 1'b0, 32'd1000);
        // skip-slow just inside and at the recheck window
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b1, 32'd1005);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b1, 32'd1010);
        // older report keeps the unhealthy mark, newer one clears it
        queue_beat(wcbt_pkg::OP_REPORT, 6'd0, 1'b0, 1'b0, 32'd50, EK_OTHER, 1'b0, 32'd1011);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b1, 32'd1012);
        queue_beat(wcbt_pkg::OP_REPORT, 6'd0, 1'b0, 1'b0, 32'd200, EK_OTHER, 1'b0, 32'd1020);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b1, 32'd1021);
        // light failures of every kind until the count passes the threshold
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2000);
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, EK_TIMEOUT, 1'b0, 32'd2000);
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, EK_UNUSED, 1'b0, 32'd2000);
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2000);
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, wcbt_pkg::EK_HOST_DOWN,
                   1'b0, 32'd2001);
        // open wait exactly reached, then passed
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2060);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2061);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2062);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2062);
        queue_beat(wcbt_pkg::OP_RESTORE, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2063);
        queue_beat(wcbt_pkg::OP_REPORT, 6'd0, 1'b0, 1'b0, 32'd300, EK_OTHER, 1'b0, 32'd2070);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd2071);
        // failure on a half-open breaker, then recovery by the worker itself
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, EK_OTHER, 1'b0, 32'd3000);
        queue_beat(wcbt_pkg::OP_REPORT, 6'd0, 1'b1, 1'b0, 32'd400, EK_OTHER, 1'b0, 32'd3061);
        queue_beat(wcbt_pkg::OP_FAILURE, 6'd0, 1'b0, 1'b0, 32'd0, wcbt_pkg::EK_HOST_DOWN,
                   1'b0, 32'd3100);
        // all-ones fields and a wrapped clock on the last worker
        queue_beat(wcbt_pkg::OP_REPORT, 6'd63, 1'b1, 1'b1, 32'hFFFF_FFFF, EK_UNUSED, 1'b1,
                   32'hFFFF_FFFF);
        queue_beat(wcbt_pkg::OP_QUERY, 6'd63, 1'b1, 1'b1, 32'hFFFF_FFFF, EK_UNUSED, 1'b1,
                   32'd5);
        wait_idle();

        // Zero threshold and wait, maximal recheck; the unused index must change nothing
        write_reg(CFG_UNUSED_IDX, 32'h0000_0000);
        start_phase(16'd0, 32'd0, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED_IDX, $urandom);
        @(posedge clk);
        queue_random_beats(100);
        wait_idle();

        start_phase(16'($urandom_range(1, 5)), $urandom_range(0, 30), $urandom_range(0, 20));
        queue_random_beats(130);
        wait_idle();

        // Threshold of 65534, endless open wait, no recheck window
        start_phase(16'd65534, 32'hFFFF_FFFF, 32'd0);
        queue_random_beats(90);
        wait_idle();

        for (int p = 0; p < 3; p++) begin
            start_phase(16'($urandom_range(0, 6)), $urandom_range(0, 40),
                        $urandom_range(0, 30));
            queue_random_beats(130);
            wait_idle();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Hard limit on the run
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
